// ===== src/nv_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector normalize package
// Widths and stage counts shared by the normalize core and its root lanes.
// ----------------------------------------------------------------------------
package nv_pkg;

   // Input component width and output fraction bits.
   localparam int IN_WIDTH      = 32;
   localparam int OUT_FRAC_BITS = 30;

   // Output component width (sign, one integer bit, fraction).
   localparam int UNIT_WIDTH = OUT_FRAC_BITS + 2;

   // Configuration register width.
   localparam int LIMIT_WIDTH = 16;

   // Magnitude of a component, its square and the sum of three squares.
   localparam int MAG_WIDTH = IN_WIDTH;
   localparam int SQ_WIDTH  = 2 * IN_WIDTH;
   localparam int SUM_WIDTH = SQ_WIDTH + 2;

   // Result magnitude is at most 2^OUT_FRAC_BITS.
   localparam int Q_WIDTH = OUT_FRAC_BITS + 1;

   // Running product q*S and the remainder of the square-root test.
   localparam int PROD_WIDTH = Q_WIDTH + SUM_WIDTH;
   localparam int REM_WIDTH  = 2 * OUT_FRAC_BITS + SUM_WIDTH + 2;

   // One pipeline stage per result bit.
   localparam int ITER_STAGES = OUT_FRAC_BITS + 1;

endpackage

// ===== src/nv_root_lane.sv =====
// ----------------------------------------------------------------------------
// Normalize root lane
// Finds the largest q with q*q*S <= c*c*2^(2F), one result bit per stage.
// ----------------------------------------------------------------------------
module nv_root_lane (
   input  logic                              clock,
   input  logic                              in_neg,
   input  logic [nv_pkg::SUM_WIDTH-1:0]      in_sum,
   input  logic [nv_pkg::SQ_WIDTH-1:0]       in_sq,
   output logic                              out_neg,
   output logic [nv_pkg::Q_WIDTH-1:0]        out_mag
);

   localparam int NS  = nv_pkg::ITER_STAGES;
   localparam int OFB = nv_pkg::OUT_FRAC_BITS;
   localparam int RW  = nv_pkg::REM_WIDTH;
   localparam int PW  = nv_pkg::PROD_WIDTH;
   localparam int QW  = nv_pkg::Q_WIDTH;
   localparam int SW  = nv_pkg::SUM_WIDTH;

   // Stage inputs and stage registers.
   logic [RW-1:0] cur_rem  [NS];
   logic [PW-1:0] cur_prod [NS];
   logic [QW-1:0] cur_mag  [NS];
   logic [SW-1:0] cur_sum  [NS];
   logic          cur_neg  [NS];

   logic [RW-1:0] rem_ff  [NS];
   logic [PW-1:0] prod_ff [NS];
   logic [QW-1:0] mag_ff  [NS];
   logic [SW-1:0] sum_ff  [NS];
   logic          neg_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      // Bit of q decided in this stage.
      localparam int B = OFB - k;

      logic [RW-1:0] delta;
      logic          take;

      if (k == 0) begin : g_first
         // The remainder starts at c*c*2^(2F), the partial root at zero.
         assign cur_rem[k]  = RW'(in_sq) << (2 * OFB);
         assign cur_prod[k] = '0;
         assign cur_mag[k]  = '0;
         assign cur_sum[k]  = in_sum;
         assign cur_neg[k]  = in_neg;
      end else begin : g_next
         assign cur_rem[k]  = rem_ff[k-1];
         assign cur_prod[k] = prod_ff[k-1];
         assign cur_mag[k]  = mag_ff[k-1];
         assign cur_sum[k]  = sum_ff[k-1];
         assign cur_neg[k]  = neg_ff[k-1];
      end

      // Growth of q*q*S when bit B is set: 2^(B+1)*q*S + 2^(2B)*S.
      assign delta = (RW'(cur_prod[k]) << (B + 1)) + (RW'(cur_sum[k]) << (2 * B));
      assign take  = (delta <= cur_rem[k]);

      // Keep the bit if the square still fits, and update q*S with it.
      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? (cur_rem[k] - delta) : cur_rem[k];
         mag_ff[k]  <= take ? (cur_mag[k] | (QW'(1) << B)) : cur_mag[k];
         prod_ff[k] <= take ? (cur_prod[k] + (PW'(cur_sum[k]) << B)) : cur_prod[k];
         sum_ff[k]  <= cur_sum[k];
         neg_ff[k]  <= cur_neg[k];
      end
   end

   assign out_mag = mag_ff[NS-1];
   assign out_neg = neg_ff[NS-1];

endmodule

// ===== src/vector3_normalize_core.sv =====
// ----------------------------------------------------------------------------
// Vector normalize core
// Scales a 3-D Q16.16 vector to unit length in Q2.30, or flags it as zero.
// ----------------------------------------------------------------------------
// An item passes the sign, square, sum, root lane and output registers.
// Throughput: one item per cycle; busy is never raised.
// Depth is set by the root lanes, one stage per result bit (31 stages).
// Reset clears the valid bits and sets the zero limit to 0.
// The receiver cannot stall, so results leave on the strobe unconditionally.
module vector3_normalize_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [nv_pkg::IN_WIDTH-1:0]  req_vec_x,
   input  logic signed [nv_pkg::IN_WIDTH-1:0]  req_vec_y,
   input  logic signed [nv_pkg::IN_WIDTH-1:0]  req_vec_z,
   output logic                                rsp_valid,
   output logic signed [nv_pkg::UNIT_WIDTH-1:0] rsp_unit_x,
   output logic signed [nv_pkg::UNIT_WIDTH-1:0] rsp_unit_y,
   output logic signed [nv_pkg::UNIT_WIDTH-1:0] rsp_unit_z,
   output logic                                rsp_was_zero,
   input  logic                                csr_we,
   input  logic [nv_pkg::LIMIT_WIDTH-1:0]      csr_wdata
);

   localparam int NS  = nv_pkg::ITER_STAGES;
   localparam int MW  = nv_pkg::MAG_WIDTH;
   localparam int QW  = nv_pkg::SQ_WIDTH;
   localparam int SW  = nv_pkg::SUM_WIDTH;
   localparam int UW  = nv_pkg::UNIT_WIDTH;
   localparam int RW  = nv_pkg::Q_WIDTH;
   localparam int OUT_DELAY = NS + 1;

   logic [nv_pkg::LIMIT_WIDTH-1:0] limit_ff;

   logic          va_ff, vb_ff, vc_ff;
   logic [MW-1:0] mag_a_ff [3];
   logic          neg_a_ff [3];
   logic [QW-1:0] sq_b_ff  [3];
   logic          neg_b_ff [3];
   logic [QW-1:0] sq_c_ff  [3];
   logic          neg_c_ff [3];
   logic [SW-1:0] sum_c_ff;
   logic [SW-1:0] sum_in;
   logic          zero_c_ff;

   logic          vd_ff [NS];
   logic          zd_ff [NS];

   logic          lane_neg [3];
   logic [RW-1:0] lane_mag [3];
   logic [UW-1:0] unit_in  [3];

   logic [nv_pkg::IN_WIDTH-1:0] raw [3];

   assign busy = 1'b0;
   assign raw[0] = req_vec_x;
   assign raw[1] = req_vec_y;
   assign raw[2] = req_vec_z;

   // Zero limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Valid bits for the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= start;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // Sign split, square and sum of squares, one stage each.
   for (genvar i = 0; i < 3; i++) begin : g_front
      always_ff @(posedge clock) begin
         neg_a_ff[i] <= raw[i][MW-1];
         mag_a_ff[i] <= raw[i][MW-1] ? (MW'(0) - raw[i]) : raw[i];
         sq_b_ff[i]  <= QW'(mag_a_ff[i]) * QW'(mag_a_ff[i]);
         neg_b_ff[i] <= neg_a_ff[i];
         sq_c_ff[i]  <= sq_b_ff[i];
         neg_c_ff[i] <= neg_b_ff[i];
      end
   end

   assign sum_in = SW'(sq_b_ff[0]) + SW'(sq_b_ff[1]) + SW'(sq_b_ff[2]);

   always_ff @(posedge clock) begin
      sum_c_ff  <= sum_in;
      zero_c_ff <= (sum_in <= SW'(limit_ff));
   end

   // Root lanes, one per component.
   for (genvar i = 0; i < 3; i++) begin : g_lane
      nv_root_lane u_lane (
         .clock   (clock),
         .in_neg  (neg_c_ff[i]),
         .in_sum  (sum_c_ff),
         .in_sq   (sq_c_ff[i]),
         .out_neg (lane_neg[i]),
         .out_mag (lane_mag[i])
      );

      assign unit_in[i] = zd_ff[NS-1] ? '0 :
                          (lane_neg[i] ? (UW'(0) - UW'(lane_mag[i])) : UW'(lane_mag[i]));
   end

   // Valid and zero flag travel beside the lanes.
   for (genvar k = 0; k < NS; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else begin
            vd_ff[k] <= (k == 0) ? vc_ff : vd_ff[(k == 0) ? 0 : k-1];
         end
         zd_ff[k] <= (k == 0) ? zero_c_ff : zd_ff[(k == 0) ? 0 : k-1];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= vd_ff[NS-1];
      end
      rsp_unit_x   <= unit_in[0];
      rsp_unit_y   <= unit_in[1];
      rsp_unit_z   <= unit_in[2];
      rsp_was_zero <= zd_ff[NS-1];
   end

   // Every item that reaches the sum stage leaves on the strobe.
   a_valid_reaches_out: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> ##OUT_DELAY rsp_valid)
      else $error("item lost between sum stage and output");

   // A flagged result is the zero vector.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_zero) |->
         (rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0))
      else $error("zero flag with nonzero components");

   // A unit vector always has a nonzero component.
   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_zero) |->
         (rsp_unit_x != '0 || rsp_unit_y != '0 || rsp_unit_z != '0))
      else $error("normalized vector came out all zero");

endmodule
